@@ rtl/core/sult_pkg.sv @@
// Shared types, codes and elaboration helpers for the sorted label table.
package sult_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int RADIX     = 32;
    localparam int LABEL_W   = 32;
    localparam int INDEX_W   = 10;
    localparam int POS_FW    = 10;
    localparam int COUNT_FW  = 11;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_PRESENT  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_DONE     = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [LABEL_W-1:0]  label;
        logic [INDEX_W-1:0]  index;
    } sult_cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [POS_FW-1:0]   position;
        logic [COUNT_FW-1:0] count;
        logic [LABEL_W-1:0]  read_value;
    } sult_res_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                shift;
        logic [LABEL_W-1:0]  label;
        logic [INDEX_W-1:0]  index;
    } sult_ctl_t;

    // word count after r radix reductions
    function automatic int reduce_count(input int n, input int r);
        int m;
        m = n;
        for (int i = 0; i < r; i++) begin
            m = (m + RADIX - 1) / RADIX;
        end
        return m;
    endfunction

    function automatic int tree_levels(input int n);
        int m;
        int l;
        m = n;
        l = 0;
        do begin
            m = (m + RADIX - 1) / RADIX;
            l++;
        end while (m > 1);
        return l;
    endfunction

    // first node of a level in the flat node array
    function automatic int level_offset(input int n, input int l);
        int s;
        s = 0;
        for (int i = 0; i < l; i++) begin
            s += reduce_count(n, i + 1);
        end
        return s;
    endfunction

endpackage

@@ rtl/core/sult_cell.sv @@
// One table cell: holds an entry, compares it with the label, shifts on insert.
module sult_cell #(
    parameter int IDX = 0,
    parameter int PW  = 10,
    parameter int CW  = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sult_pkg::sult_ctl_t                ctl,
    input  logic [CW-1:0]                      count,
    input  logic [sult_pkg::LABEL_W-1:0]       entry_prev,
    input  logic                               lt_prev,
    output logic [sult_pkg::LABEL_W-1:0]       entry,
    output logic                               lt,
    output logic [2+PW+sult_pkg::LABEL_W-1:0]  leaf
);

    localparam bit IDX_READABLE = IDX < (1 << sult_pkg::INDEX_W);

    logic [sult_pkg::LABEL_W-1:0] entry_reg, entry_next;
    logic                         lt_reg, lt_next;
    logic                         eq_reg, eq_next;
    logic                         hit_reg, hit_next;
    logic                         in_use;
    logic                         bnd;

    assign in_use = CW'(IDX) < count;
    // first cell not below the label: insertion point or match
    assign bnd    = !lt_reg && lt_prev;

    always_comb
    begin
        lt_next  = in_use && (entry_reg < ctl.label);
        eq_next  = in_use && (entry_reg == ctl.label);
        hit_next = in_use && IDX_READABLE
                   && (sult_pkg::INDEX_W'(IDX) == ctl.index);
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            if (bnd)
                entry_next = ctl.label;
            else if (!lt_reg)
                entry_next = entry_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign leaf  = {eq_reg, bnd,
                    bnd ? PW'(IDX) : {PW{1'b0}},
                    hit_reg ? entry_reg : {sult_pkg::LABEL_W{1'b0}}};

endmodule

@@ rtl/core/sult_or_tree.sv @@
// Registered radix-32 OR reduction of one-hot cell words.
module sult_or_tree #(
    parameter int N = 1024,
    parameter int W = 44
) (
    input  logic         clk,
    input  logic [W-1:0] leaves [N],
    output logic [W-1:0] root
);

    localparam int LEVELS = sult_pkg::tree_levels(N);
    localparam int TOTAL  = sult_pkg::level_offset(N, LEVELS);

    logic [W-1:0] node_w [TOTAL];

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        localparam int PREV     = sult_pkg::reduce_count(N, l);
        localparam int CUR      = sult_pkg::reduce_count(N, l + 1);
        localparam int OFF      = sult_pkg::level_offset(N, l);
        localparam int OFF_PREV = (l == 0) ? 0 : sult_pkg::level_offset(N, l - 1);

        for (genvar k = 0; k < CUR; k++)
        begin : g_node
            logic [W-1:0] kids [sult_pkg::RADIX];
            logic [W-1:0] acc;
            logic [W-1:0] q_reg;

            for (genvar j = 0; j < sult_pkg::RADIX; j++)
            begin : g_kid
                if (k * sult_pkg::RADIX + j >= PREV)
                begin : g_none
                    assign kids[j] = '0;
                end
                else if (l == 0)
                begin : g_leaf
                    assign kids[j] = leaves[k * sult_pkg::RADIX + j];
                end
                else
                begin : g_node_in
                    assign kids[j] = node_w[OFF_PREV + k * sult_pkg::RADIX + j];
                end
            end

            always_comb
            begin
                acc = '0;
                for (int j = 0; j < sult_pkg::RADIX; j++)
                begin
                    acc = acc | kids[j];
                end
            end

            always_ff @(posedge clk)
            begin
                q_reg <= acc;
            end

            assign node_w[OFF + k] = q_reg;
        end
    end

    assign root = node_w[TOTAL-1];

endmodule

@@ rtl/core/sorted_unique_label_table.sv @@
// Top level: sorted unique label table built as a chain of compare cells.
//
// Command port: a transfer takes place at a clock edge with start high and busy
// low. Each command yields one result, shown on result for exactly one cycle
// with done high; the receiver cannot stall it, so it must take every result.
// A command occupies the block from its transfer to the earliest next transfer:
// S_CMP for the registered compare in every cell, S_RED for the registered
// radix-32 reduction that finds the insertion point, match and read word, S_OUT
// to commit the shift and register the result, and then S_IDLE with done high
// and busy low, at whose closing edge the next command may transfer. Clear only
// zeroes the count; there is no clearing pass after reset.
module sorted_unique_label_table #(
    parameter int DEPTH = sult_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sult_pkg::sult_cmd_t cmd,
    output logic                done,
    output sult_pkg::sult_res_t result
);

    localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int LW     = 2 + PW + sult_pkg::LABEL_W;
    localparam int LEVELS = sult_pkg::tree_levels(DEPTH);
    localparam int LCW    = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [LCW-1:0]      lvl_reg;
    logic [CW-1:0]       count_reg;
    sult_pkg::sult_cmd_t cmd_reg;
    logic                done_reg;
    sult_pkg::sult_res_t result_reg;
    sult_pkg::sult_res_t result_next;

    sult_pkg::sult_ctl_t          ctl;
    logic [sult_pkg::LABEL_W-1:0] entry_w [DEPTH];
    logic                         lt_w    [DEPTH];
    logic [LW-1:0]                leaf_w  [DEPTH];
    logic [LW-1:0]                root;

    logic                         root_eq;
    logic [PW-1:0]                root_pos;
    logic [sult_pkg::LABEL_W-1:0] root_rd;
    logic                         full;
    logic                         do_shift;

    assign root_eq  = root[LW-1];
    assign root_pos = root[PW+sult_pkg::LABEL_W-1:sult_pkg::LABEL_W];
    assign root_rd  = root[sult_pkg::LABEL_W-1:0];
    assign full     = count_reg == CW'(DEPTH);
    assign do_shift = (state_reg == S_OUT) && (cmd_reg.action == sult_pkg::ACT_INSERT)
                      && !root_eq && !full;

    assign ctl.shift = do_shift;
    assign ctl.label = cmd_reg.label;
    assign ctl.index = cmd_reg.index;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sult_cell #(.IDX(i), .PW(PW), .CW(CW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .entry_prev (cmd_reg.label),
                .lt_prev    (1'b1),
                .entry      (entry_w[i]),
                .lt         (lt_w[i]),
                .leaf       (leaf_w[i])
            );
        end
        else
        begin : g_body
            sult_cell #(.IDX(i), .PW(PW), .CW(CW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .entry_prev (entry_w[i-1]),
                .lt_prev    (lt_w[i-1]),
                .entry      (entry_w[i]),
                .lt         (lt_w[i]),
                .leaf       (leaf_w[i])
            );
        end
    end

    sult_or_tree #(.N(DEPTH), .W(LW)) u_tree (
        .clk    (clk),
        .leaves (leaf_w),
        .root   (root)
    );

    // result word for the command in flight, valid in S_OUT
    always_comb
    begin
        result_next        = '0;
        result_next.status = sult_pkg::STAT_DONE;
        result_next.count  = sult_pkg::COUNT_FW'(count_reg);
        case (cmd_reg.action)
            sult_pkg::ACT_INSERT:
            begin
                if (root_eq)
                begin
                    result_next.status   = sult_pkg::STAT_PRESENT;
                    result_next.position = sult_pkg::POS_FW'(root_pos);
                end
                else if (full)
                begin
                    result_next.status = sult_pkg::STAT_FULL;
                end
                else
                begin
                    result_next.status   = sult_pkg::STAT_INSERTED;
                    result_next.position = sult_pkg::POS_FW'(root_pos);
                    result_next.count    = sult_pkg::COUNT_FW'(count_reg + 1'b1);
                end
            end
            sult_pkg::ACT_READ:
            begin
                result_next.read_value = root_rd;
            end
            sult_pkg::ACT_CLEAR:
            begin
                result_next.count = '0;
            end
            default:
            begin
                result_next.status = sult_pkg::STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lvl_reg    <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= state_reg == S_OUT;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    lvl_reg   <= '0;
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    if (lvl_reg == LCW'(LEVELS - 1))
                        state_reg <= S_OUT;
                    else
                        lvl_reg <= lvl_reg + 1'b1;
                end
                S_OUT:
                begin
                    state_reg  <= S_IDLE;
                    result_reg <= result_next;
                    if (do_shift)
                        count_reg <= count_reg + 1'b1;
                    else if (cmd_reg.action == sult_pkg::ACT_CLEAR)
                        count_reg <= '0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // command latch
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while a command is still in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted command did not occupy the block");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == sult_pkg::STAT_INSERTED
        |-> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table by one");

endmodule
